>>> hdl/xmr_pkg.sv
// ----------------------------------------------------------------------------
// xmr_pkg
// shared types, constants and the control store of the random generator
// ----------------------------------------------------------------------------
package xmr_pkg;

  // generator constants
  localparam logic [63:0] DEFAULT_FIRST  = 64'h243f_6a88_85a3_08d3;
  localparam logic [63:0] DEFAULT_SECOND = 64'h1319_8a2e_0370_7344;
  localparam logic [63:0] SEED_MIX       = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [63:0] GOLDEN_MUL     = 64'h9e37_79b9_7f4a_7c15;
  localparam int unsigned ROT_A   = 24;
  localparam int unsigned SHIFT_B = 16;
  localparam int unsigned ROT_C   = 37;

  // remainder unit
  localparam int unsigned MOD_STEPS = 64;
  localparam int unsigned CNT_W     = $clog2(MOD_STEPS);
  localparam int unsigned SPAN_W    = 32;

  // config port
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 64;
  localparam logic        REG_SEED = 1'b0;

  typedef enum logic [1:0] {
    CMD_RESEED = 2'd0,
    CMD_DRAW64 = 2'd1,
    CMD_DRAW32 = 2'd2,
    CMD_RANGE  = 2'd3
  } cmd_e;

  // sequencer
  localparam int unsigned UPC_W = 3;
  localparam logic [UPC_W-1:0] STEP_IDLE   = 3'd0;
  localparam logic [UPC_W-1:0] STEP_RESEED = 3'd1;
  localparam logic [UPC_W-1:0] STEP_MUL_LL = 3'd2;
  localparam logic [UPC_W-1:0] STEP_MUL_LH = 3'd3;
  localparam logic [UPC_W-1:0] STEP_MUL_HL = 3'd4;
  localparam logic [UPC_W-1:0] STEP_MOD    = 3'd5;
  localparam logic [UPC_W-1:0] STEP_EMIT   = 3'd6;

  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_FETCH,
    JMP_RET,
    JMP_NOT_RANGE,
    JMP_LOOP
  } jump_e;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_LL,
    MUL_LH,
    MUL_HL
  } mul_sel_e;

  typedef enum logic [1:0] {
    ST_HOLD,
    ST_ADVANCE,
    ST_SEED
  } state_op_e;

  typedef struct packed {
    jump_e           jump;
    logic [UPC_W-1:0] target;
    mul_sel_e        mul_sel;
    state_op_e       state_op;
    logic            mod_step;
    logic            emit;
  } ctl_word_t;

  typedef struct packed {
    logic clear;
    logic step;
  } mod_ctl_t;

  function automatic ctl_word_t ctl_rom(input logic [UPC_W-1:0] upc);
    ctl_word_t w;
    w = '{jump: JMP_NEXT, target: STEP_IDLE, mul_sel: MUL_NONE,
          state_op: ST_HOLD, mod_step: 1'b0, emit: 1'b0};
    unique case (upc)
      STEP_IDLE: begin
        w.jump = JMP_FETCH;
      end
      STEP_RESEED: begin
        w.jump     = JMP_RET;
        w.state_op = ST_SEED;
      end
      STEP_MUL_LL: begin
        w.mul_sel = MUL_LL;
      end
      STEP_MUL_LH: begin
        w.mul_sel = MUL_LH;
      end
      STEP_MUL_HL: begin
        w.jump     = JMP_NOT_RANGE;
        w.target   = STEP_EMIT;
        w.mul_sel  = MUL_HL;
        w.state_op = ST_ADVANCE;
      end
      STEP_MOD: begin
        w.jump     = JMP_LOOP;
        w.target   = STEP_MOD;
        w.mod_step = 1'b1;
      end
      STEP_EMIT: begin
        w.jump = JMP_RET;
        w.emit = 1'b1;
      end
      default: begin
        w.jump = JMP_RET;
      end
    endcase
    return w;
  endfunction

endpackage

>>> hdl/xmr_if.sv
// ----------------------------------------------------------------------------
// xmr channel interfaces
// command beats in, result beats out, valid/ready handshake
// ----------------------------------------------------------------------------
interface xmr_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [31:0] low_bound;
  logic signed [31:0] high_bound;

  modport source (output valid, output cmd, output low_bound, output high_bound,
                  input ready);
  modport sink   (input valid, input cmd, input low_bound, input high_bound,
                  output ready);
endinterface

interface xmr_res_if;
  logic               valid;
  logic               ready;
  logic [63:0]        wide_value;
  logic signed [31:0] range_value;

  modport source (output valid, output wide_value, output range_value, input ready);
  modport sink   (input valid, input wide_value, input range_value, output ready);
endinterface

>>> hdl/xmr_mod_unit.sv
// ----------------------------------------------------------------------------
// xmr_mod_unit
// radix-2 remainder unit, one dividend bit per step, msb first
// ----------------------------------------------------------------------------
module xmr_mod_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  xmr_pkg::mod_ctl_t               ctl_i,
  input  logic [xmr_pkg::SPAN_W-1:0]      span_i,
  input  logic                            bit_i,
  output logic [xmr_pkg::SPAN_W-1:0]      rem_o,
  output logic                            done_o
);

  logic [xmr_pkg::SPAN_W-1:0] span_q;
  logic [xmr_pkg::SPAN_W-1:0] rem_q, rem_d;
  logic [xmr_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [xmr_pkg::SPAN_W:0]   trial;
  logic [xmr_pkg::SPAN_W:0]   diff;

  // remainder stays below span, so the shifted trial fits one extra bit
  assign trial = {rem_q, bit_i};
  assign diff  = trial - {1'b0, span_q};

  always_comb begin
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (ctl_i.clear) begin
      rem_d = '0;
      cnt_d = xmr_pkg::CNT_W'(xmr_pkg::MOD_STEPS - 1);
    end else if (ctl_i.step) begin
      if (trial >= {1'b0, span_q}) begin
        rem_d = diff[xmr_pkg::SPAN_W-1:0];
      end else begin
        rem_d = trial[xmr_pkg::SPAN_W-1:0];
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rem_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.clear) begin
      span_q <= span_i;
    end
  end

  assign rem_o  = rem_q;
  assign done_o = (cnt_q == '0);

endmodule

>>> hdl/xoroshiro_multiply_random.sv
// ----------------------------------------------------------------------------
// xoroshiro_multiply_random
// 128-bit xoroshiro generator with golden-ratio multiply output, run by a
// small microprogram over a shared 32x32 multiplier and a remainder unit
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+----------------------------------
//  cmd_i   | in  | valid/ready          | cmd, low_bound, high_bound
//  res_o   | out | valid/ready          | wide_value, range_value
//  apb     | in  | psel/penable/pready  | paddr_i, pwdata_i, prdata_o (seed)
//
//  a range draw adds the 64-step remainder loop; every draw spends
//  three steps on the 32x32 partial products of the multiplier
//  one command is worked at a time; the result register lets the next
//  command in while a result waits, a full register stalls only the emit step
//  reset restores the default state pair and a zero seed, no clearing pass
//
module xoroshiro_multiply_random (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  xmr_cmd_if.sink                       cmd_i,
  xmr_res_if.source                     res_o,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [xmr_pkg::APB_AW-1:0]    paddr_i,
  input  logic [xmr_pkg::APB_DW-1:0]    pwdata_i,
  output logic [xmr_pkg::APB_DW-1:0]    prdata_o,
  output logic                          pready_o
);

  // sequencer
  logic [xmr_pkg::UPC_W-1:0] upc_q, upc_d;
  xmr_pkg::ctl_word_t        ctl;

  // latched command
  xmr_pkg::cmd_e      cmd_q;
  logic signed [31:0] low_q;

  // generator state and product accumulator
  logic [63:0] s0_q, s0_d;
  logic [63:0] s1_q, s1_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] seed_q;

  // result register
  logic               out_valid_q, out_valid_d;
  logic [63:0]        wide_q;
  logic signed [31:0] range_q;
  logic [63:0]        wide_next;
  logic signed [31:0] range_next;

  logic        in_fire;
  logic        out_free;
  logic        hold;
  logic        load_out;
  logic        empty_range;
  logic [32:0] span_full;
  logic [31:0] mul_a, mul_b;
  logic [63:0] pp;
  logic [63:0] mix_t;
  logic [31:0] rem;
  logic        mod_done;
  xmr_pkg::mod_ctl_t mod_ctl;

  assign ctl = xmr_pkg::ctl_rom(upc_q);

  // ---------------------------------------------------------------- handshake
  assign cmd_i.ready = (upc_q == xmr_pkg::STEP_IDLE);
  assign in_fire     = cmd_i.valid && cmd_i.ready;
  assign out_free    = !out_valid_q || res_o.ready;
  assign hold        = ctl.emit && !out_free;
  assign load_out    = ctl.emit && out_free;

  assign empty_range = !(cmd_i.low_bound < cmd_i.high_bound);
  // exact difference; only used when positive, then it fits 32 bits
  assign span_full   = {cmd_i.high_bound[31], cmd_i.high_bound}
                     - {cmd_i.low_bound[31], cmd_i.low_bound};

  // ---------------------------------------------------------------- next step
  always_comb begin
    upc_d = upc_q;
    unique case (ctl.jump)
      xmr_pkg::JMP_NEXT: begin
        upc_d = upc_q + 1'b1;
      end
      xmr_pkg::JMP_FETCH: begin
        if (in_fire) begin
          unique case (xmr_pkg::cmd_e'(cmd_i.cmd))
            xmr_pkg::CMD_RESEED: upc_d = xmr_pkg::STEP_RESEED;
            xmr_pkg::CMD_RANGE: begin
              // empty range answers low_bound, state untouched
              upc_d = empty_range ? xmr_pkg::STEP_EMIT : xmr_pkg::STEP_MUL_LL;
            end
            default: upc_d = xmr_pkg::STEP_MUL_LL;
          endcase
        end
      end
      xmr_pkg::JMP_RET: begin
        upc_d = hold ? upc_q : xmr_pkg::STEP_IDLE;
      end
      xmr_pkg::JMP_NOT_RANGE: begin
        upc_d = (cmd_q != xmr_pkg::CMD_RANGE) ? ctl.target : upc_q + 1'b1;
      end
      xmr_pkg::JMP_LOOP: begin
        upc_d = !mod_done ? ctl.target : upc_q + 1'b1;
      end
      default: begin
        upc_d = xmr_pkg::STEP_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= xmr_pkg::STEP_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= xmr_pkg::cmd_e'(cmd_i.cmd);
      low_q <= cmd_i.low_bound;
    end
  end

  // ---------------------------------------------------------------- multiplier
  // low 64 bits of s0 * golden: lo*lo, then lo*hi and hi*lo into the top half
  always_comb begin
    mul_a = s0_q[31:0];
    mul_b = xmr_pkg::GOLDEN_MUL[31:0];
    unique case (ctl.mul_sel)
      xmr_pkg::MUL_LH: mul_b = xmr_pkg::GOLDEN_MUL[63:32];
      xmr_pkg::MUL_HL: mul_a = s0_q[63:32];
      default: ;
    endcase
  end

  assign pp = {32'h0, mul_a} * {32'h0, mul_b};

  always_comb begin
    acc_d = acc_q;
    unique case (ctl.mul_sel)
      xmr_pkg::MUL_LL: acc_d = pp;
      xmr_pkg::MUL_LH,
      xmr_pkg::MUL_HL: acc_d = {acc_q[63:32] + pp[31:0], acc_q[31:0]};
      default: begin
        // remainder loop eats the product msb first
        if (ctl.mod_step) begin
          acc_d = {acc_q[62:0], 1'b0};
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // ---------------------------------------------------------------- state
  assign mix_t = s1_q ^ s0_q;

  always_comb begin
    s0_d = s0_q;
    s1_d = s1_q;
    unique case (ctl.state_op)
      xmr_pkg::ST_ADVANCE: begin
        s0_d = ((s0_q << xmr_pkg::ROT_A) | (s0_q >> (64 - xmr_pkg::ROT_A)))
             ^ mix_t ^ (mix_t << xmr_pkg::SHIFT_B);
        s1_d = (mix_t << xmr_pkg::ROT_C) | (mix_t >> (64 - xmr_pkg::ROT_C));
      end
      xmr_pkg::ST_SEED: begin
        if (seed_q == '0) begin
          s0_d = xmr_pkg::DEFAULT_FIRST;
          s1_d = xmr_pkg::DEFAULT_SECOND;
        end else begin
          s0_d = seed_q ^ xmr_pkg::SEED_MIX;
          s1_d = seed_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q <= xmr_pkg::DEFAULT_FIRST;
      s1_q <= xmr_pkg::DEFAULT_SECOND;
    end else begin
      s0_q <= s0_d;
      s1_q <= s1_d;
    end
  end

  // ---------------------------------------------------------------- remainder
  // cleared on every accept so an empty range adds zero to low_bound
  assign mod_ctl.clear = in_fire;
  assign mod_ctl.step  = ctl.mod_step;

  xmr_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mod_ctl),
    .span_i (span_full[xmr_pkg::SPAN_W-1:0]),
    .bit_i  (acc_q[63]),
    .rem_o  (rem),
    .done_o (mod_done)
  );

  // ---------------------------------------------------------------- result
  always_comb begin
    wide_next  = '0;
    range_next = '0;
    unique case (cmd_q)
      xmr_pkg::CMD_DRAW64: wide_next = acc_q;
      xmr_pkg::CMD_DRAW32: wide_next = {32'h0, acc_q[63:32]};
      xmr_pkg::CMD_RANGE:  range_next = low_q + $signed(rem);
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      wide_q  <= wide_next;
      range_q <= range_next;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.wide_value  = wide_q;
  assign res_o.range_value = range_q;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (psel_i && penable_i && pwrite_i && pready_o
                 && (paddr_i[3] == xmr_pkg::REG_SEED)) begin
      seed_q <= pwdata_i;
    end
  end

  assign prdata_o = (paddr_i[3] == xmr_pkg::REG_SEED) ? seed_q : '0;
  assign pready_o = 1'b1;

endmodule

>>> hdl/xmr_checker.sv
// ----------------------------------------------------------------------------
// xmr_checker
// port-level checks on the random generator, bound to the top level
// ----------------------------------------------------------------------------
module xmr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [63:0] wide_value_i,
  input logic [31:0] range_value_i,
  input logic        pready_i
);

  // result beat holds while stalled
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result beat dropped while stalled");

  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(wide_value_i) && $stable(range_value_i))
    else $error("result payload changed while stalled");

  // one command in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("command taken while the previous one still runs");

  // a result carries either a wide draw or a range draw
  a_one_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (wide_value_i == 64'h0) || (range_value_i == 32'h0))
    else $error("both result fields nonzero");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready_i)
    else $error("config port not ready");

endmodule

bind xoroshiro_multiply_random xmr_checker u_xmr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (cmd_i.valid),
  .in_ready_i    (cmd_i.ready),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .wide_value_i  (res_o.wide_value),
  .range_value_i (res_o.range_value),
  .pready_i      (pready_o)
);
